@@ src/ccf_pkg.sv @@
// Shared types, widths and helpers for the cross convolution filter.
// Used by ccf_tap_cell, ccf_scale_stage and cross_convolution_5tap; no dependencies.
package ccf_pkg;

    localparam int TAP_COUNT    = 5;
    localparam int COEF_BITS    = 12;
    localparam int SAMPLE_W     = 16;
    localparam int INPUT_TAPS   = 5;   // column samples given per item
    localparam int ROW_TAPS     = 4;   // row neighbors given per item
    localparam int TAP_REG_W    = 60;
    localparam int SCALE_W      = 32;
    localparam int FRAC_BITS    = 24;
    localparam int BIAS_SHIFT   = 16;
    localparam int SCALE_STAGES = 4;

    localparam int SUM_W      = SAMPLE_W + 1 + COEF_BITS + $clog2(TAP_COUNT);
    localparam int PROD_W     = SUM_W + SCALE_W;
    localparam int TOT_W      = (PROD_W > 64) ? PROD_W : 64;
    localparam int Q_W        = TOT_W - FRAC_BITS;
    localparam int TAPS_EXT_W = TAP_REG_W + TAP_COUNT * COEF_BITS;
    localparam int LATENCY    = 2 * (TAP_COUNT + SCALE_STAGES);

    localparam int CFG_DATA_W  = TAP_REG_W;
    localparam int CFG_INDEX_W = 3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_DEPTH     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VERTICAL_TAPS    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HORIZONTAL_TAPS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VERTICAL_SCALE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HORIZONTAL_SCALE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_BIAS      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_NEGATIVES  = 3'd6;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX_16 = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX_8  = 16'h00FF;
    localparam logic [SCALE_W-1:0]  SCALE_ONE     = 32'h0100_0000;

    typedef logic [SAMPLE_W-1:0]              sample_t;
    typedef logic signed [COEF_BITS-1:0]      coef_t;
    typedef logic [TAP_REG_W-1:0]             taps_t;
    typedef logic signed [SCALE_W-1:0]        scale_t;
    typedef logic [CFG_INDEX_W-1:0]           cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]            cfg_data_t;
    typedef sample_t [TAP_COUNT-1:0]          tap_vec_t;
    typedef sample_t [ROW_TAPS-1:0]           row_t;

    // what one cell hands to the next
    typedef struct packed {
        logic                     valid;
        tap_vec_t                 smp;
        logic signed [SUM_W-1:0]  sum;
        row_t                     row;
    } cell_bus_t;

    // result of one scale pipeline
    typedef struct packed {
        logic    valid;
        sample_t value;
        row_t    row;
    } pass_out_t;

    // coefficient idx of a packed tap register; bits past the register read as zero
    function automatic coef_t coef_at(input taps_t taps, input int idx);
        logic [TAPS_EXT_W-1:0] ext;
        ext = TAPS_EXT_W'(taps);
        return coef_t'(ext[idx*COEF_BITS +: COEF_BITS]);
    endfunction

endpackage

@@ src/ccf_tap_cell.sv @@
// One multiply-accumulate cell of a tap chain.
// Depends on ccf_pkg for the bus struct and widths.
module ccf_tap_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  ccf_pkg::coef_t    coef,
    input  ccf_pkg::cell_bus_t bus_in,
    output ccf_pkg::cell_bus_t bus_out
);
    import ccf_pkg::*;

    logic                              valid_reg;
    logic                              valid_next;
    tap_vec_t                          smp_reg;
    tap_vec_t                          smp_next;
    logic signed [SUM_W-1:0]           sum_reg;
    logic signed [SUM_W-1:0]           sum_next;
    row_t                              row_reg;
    logic signed [SAMPLE_W+COEF_BITS:0] prod;

    assign valid_next = bus_in.valid;
    assign prod       = $signed({1'b0, bus_in.smp[0]}) * coef;
    assign sum_next   = bus_in.sum + SUM_W'(prod);

    // advance the sample vector by one tap
    always_comb
    begin
        for (int i = 0; i < TAP_COUNT - 1; i++)
        begin
            smp_next[i] = bus_in.smp[i+1];
        end
        smp_next[TAP_COUNT-1] = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
        sum_reg <= sum_next;
        row_reg <= bus_in.row;
    end

    assign bus_out.valid = valid_reg;
    assign bus_out.smp   = smp_reg;
    assign bus_out.sum   = sum_reg;
    assign bus_out.row   = row_reg;

endmodule

@@ src/ccf_scale_stage.sv @@
// Four-stage scale pipeline: multiply, saturate and bias, magnitude, shift and clip.
// Depends on ccf_pkg for the bus structs and widths.
module ccf_scale_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  ccf_pkg::cell_bus_t  bus_in,
    input  ccf_pkg::scale_t     scale,
    input  ccf_pkg::scale_t     bias,
    input  logic                with_bias,
    input  logic                clamp_neg,
    input  ccf_pkg::sample_t    max_value,
    output ccf_pkg::pass_out_t  pass_out
);
    import ccf_pkg::*;

    localparam logic signed [TOT_W-1:0] MAG_LIMIT =
        signed'(TOT_W'(64'h4000_0000_0000_0000));

    logic [SCALE_STAGES-1:0]    valid_reg;
    logic [SCALE_STAGES-1:0]    valid_next;
    row_t                       row_reg [SCALE_STAGES];

    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [TOT_W-1:0]    prod_ext;
    logic signed [TOT_W-1:0]    sat;
    logic signed [TOT_W-1:0]    bias_term;
    logic signed [TOT_W-1:0]    tot_reg;
    logic signed [TOT_W-1:0]    tot_next;
    logic [TOT_W-1:0]           mag_reg;
    logic [TOT_W-1:0]           mag_next;
    logic                       neg_reg;
    logic [Q_W-1:0]             q;
    sample_t                    value_reg;
    sample_t                    value_next;

    assign valid_next = {valid_reg[SCALE_STAGES-2:0], bus_in.valid};
    assign prod_next  = bus_in.sum * scale;

    always_comb
    begin
        prod_ext = TOT_W'(prod_reg);
        // saturate the product magnitude
        if (prod_ext > MAG_LIMIT)
        begin
            sat = MAG_LIMIT;
        end
        else if (prod_ext < -MAG_LIMIT)
        begin
            sat = -MAG_LIMIT;
        end
        else
        begin
            sat = prod_ext;
        end
        bias_term = with_bias ? (TOT_W'(bias) <<< BIAS_SHIFT) : '0;
        tot_next  = sat + bias_term;
    end

    assign mag_next = tot_reg[TOT_W-1] ? TOT_W'(-tot_reg) : TOT_W'(tot_reg);

    // truncation toward zero is the shifted magnitude
    always_comb
    begin
        q = mag_reg[TOT_W-1:FRAC_BITS];
        if (neg_reg && clamp_neg)
        begin
            value_next = '0;
        end
        else if (q > Q_W'(max_value))
        begin
            value_next = max_value;
        end
        else
        begin
            value_next = q[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        tot_reg    <= tot_next;
        mag_reg    <= mag_next;
        neg_reg    <= tot_reg[TOT_W-1];
        value_reg  <= value_next;
        row_reg[0] <= bus_in.row;
        for (int i = 1; i < SCALE_STAGES; i++)
        begin
            row_reg[i] <= row_reg[i-1];
        end
    end

    assign pass_out.valid = valid_reg[SCALE_STAGES-1];
    assign pass_out.value = value_reg;
    assign pass_out.row   = row_reg[SCALE_STAGES-1];

endmodule

@@ src/cross_convolution_5tap.sv @@
// Top level of the cross convolution filter: config registers, two tap chains, two scalers.
// Depends on ccf_pkg, ccf_tap_cell and ccf_scale_stage.
//
//  channel   | handshake        | payload
//  ----------+------------------+-------------------------------------------------
//  item in   | start, busy      | column_top2..column_bottom2, row_left2..row_right2
//  result    | done (strobe)    | filtered_pixel
//  config    | cfg_write        | cfg_index, cfg_wdata
//
// One item per cycle; busy stays low. Each result is registered in turn through the
// vertical cell chain, its four-stage scaler, the horizontal cell chain and its scaler,
// one register per step.
// Reset clears the valid bits of every stage and loads the register defaults.
// The receiver cannot stall; done is high for one cycle per result.
module cross_convolution_5tap (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ccf_pkg::sample_t     column_top2,
    input  ccf_pkg::sample_t     column_top1,
    input  ccf_pkg::sample_t     column_center,
    input  ccf_pkg::sample_t     column_bottom1,
    input  ccf_pkg::sample_t     column_bottom2,
    input  ccf_pkg::sample_t     row_left2,
    input  ccf_pkg::sample_t     row_left1,
    input  ccf_pkg::sample_t     row_right1,
    input  ccf_pkg::sample_t     row_right2,
    output logic                 done,
    output ccf_pkg::sample_t     filtered_pixel,
    input  logic                 cfg_write,
    input  ccf_pkg::cfg_index_t  cfg_index,
    input  ccf_pkg::cfg_data_t   cfg_wdata
);
    import ccf_pkg::*;

    logic       mode_reg;
    taps_t      vtaps_reg;
    taps_t      htaps_reg;
    scale_t     vscale_reg;
    scale_t     hscale_reg;
    scale_t     bias_reg;
    logic       clamp_reg;

    sample_t                      max_value;
    sample_t [INPUT_TAPS-1:0]     col_in;
    row_t                         row_in;
    logic                         accept;
    cell_bus_t                    vbus [TAP_COUNT+1];
    cell_bus_t                    hbus [TAP_COUNT+1];
    pass_out_t                    vout;
    pass_out_t                    hout;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign max_value = mode_reg ? SAMPLE_MAX_16 : SAMPLE_MAX_8;

    // drop the upper byte of every sample in 8-bit mode
    assign col_in[0] = column_top2    & max_value;
    assign col_in[1] = column_top1    & max_value;
    assign col_in[2] = column_center  & max_value;
    assign col_in[3] = column_bottom1 & max_value;
    assign col_in[4] = column_bottom2 & max_value;
    assign row_in[0] = row_left2      & max_value;
    assign row_in[1] = row_left1      & max_value;
    assign row_in[2] = row_right1     & max_value;
    assign row_in[3] = row_right2     & max_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            vtaps_reg  <= '0;
            htaps_reg  <= '0;
            vscale_reg <= SCALE_ONE;
            hscale_reg <= SCALE_ONE;
            bias_reg   <= '0;
            clamp_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SAMPLE_DEPTH:     mode_reg   <= cfg_wdata[0];
                REG_VERTICAL_TAPS:    vtaps_reg  <= cfg_wdata[TAP_REG_W-1:0];
                REG_HORIZONTAL_TAPS:  htaps_reg  <= cfg_wdata[TAP_REG_W-1:0];
                REG_VERTICAL_SCALE:   vscale_reg <= cfg_wdata[SCALE_W-1:0];
                REG_HORIZONTAL_SCALE: hscale_reg <= cfg_wdata[SCALE_W-1:0];
                REG_OUTPUT_BIAS:      bias_reg   <= cfg_wdata[SCALE_W-1:0];
                REG_CLAMP_NEGATIVES:  clamp_reg  <= cfg_wdata[0];
                default:              ;
            endcase
        end
    end

    // vertical chain head; taps beyond the given column see zero
    assign vbus[0].valid = accept;
    assign vbus[0].sum   = '0;
    assign vbus[0].row   = row_in;

    for (genvar i = 0; i < TAP_COUNT; i++)
    begin : g_vsmp
        if (i < INPUT_TAPS)
        begin : g_col
            assign vbus[0].smp[i] = col_in[i];
        end
        else
        begin : g_zero
            assign vbus[0].smp[i] = '0;
        end
    end

    for (genvar i = 0; i < TAP_COUNT; i++)
    begin : g_vcell
        ccf_tap_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .coef    (coef_at(vtaps_reg, i)),
            .bus_in  (vbus[i]),
            .bus_out (vbus[i+1])
        );
    end

    ccf_scale_stage u_vscale (
        .clk       (clk),
        .rst_n     (rst_n),
        .bus_in    (vbus[TAP_COUNT]),
        .scale     (vscale_reg),
        .bias      (bias_reg),
        .with_bias (1'b0),
        .clamp_neg (clamp_reg),
        .max_value (max_value),
        .pass_out  (vout)
    );

    // horizontal chain head; the vertical result is the centre tap
    assign hbus[0].valid = vout.valid;
    assign hbus[0].sum   = '0;
    assign hbus[0].row   = '0;

    for (genvar i = 0; i < TAP_COUNT; i++)
    begin : g_hsmp
        if (i < 2)
        begin : g_left
            assign hbus[0].smp[i] = vout.row[i];
        end
        else if (i == 2)
        begin : g_centre
            assign hbus[0].smp[i] = vout.value;
        end
        else if (i < INPUT_TAPS)
        begin : g_right
            assign hbus[0].smp[i] = vout.row[i-1];
        end
        else
        begin : g_zero
            assign hbus[0].smp[i] = '0;
        end
    end

    for (genvar i = 0; i < TAP_COUNT; i++)
    begin : g_hcell
        ccf_tap_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .coef    (coef_at(htaps_reg, i)),
            .bus_in  (hbus[i]),
            .bus_out (hbus[i+1])
        );
    end

    ccf_scale_stage u_hscale (
        .clk       (clk),
        .rst_n     (rst_n),
        .bus_in    (hbus[TAP_COUNT]),
        .scale     (hscale_reg),
        .bias      (bias_reg),
        .with_bias (1'b1),
        .clamp_neg (clamp_reg),
        .max_value (max_value),
        .pass_out  (hout)
    );

    assign done           = hout.valid;
    assign filtered_pixel = hout.value;

    // every item yields its result after the fixed pipeline depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result missing after pipeline depth");

    // no result without an item accepted the pipeline depth before
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching item");

    // 8-bit mode keeps the upper byte clear
    a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !$past(mode_reg)) |-> (filtered_pixel[SAMPLE_W-1:8] == '0))
        else $error("8-bit result out of range");

endmodule

@@ verif/cross_convolution_5tap_tb.sv @@
// Self-checking testbench for cross_convolution_5tap: directed and random pixel items
// against an in-bench model of both filter passes. Depends on ccf_pkg and the RTL top.
`timescale 1ns / 100ps

module cross_convolution_5tap_tb;
    import ccf_pkg::*;

    localparam int             STALL_LIMIT = 2000;
    localparam cfg_index_t     REG_UNUSED  = 3'd7;
    localparam bit [63:0]      PROD_LIMIT  = 64'h4000_0000_0000_0000;
    localparam longint         FRAC_DIV    = 64'sd16777216;
    localparam longint         BIAS_MUL    = 64'sd65536;

    typedef struct {
        sample_t col [5];   // top2, top1, center, bottom1, bottom2
        sample_t nbr [4];   // left2, left1, right1, right2
    } pixel_item_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    sample_t    column_top2, column_top1, column_center, column_bottom1, column_bottom2;
    sample_t    row_left2, row_left1, row_right1, row_right2;
    logic       done;
    sample_t    filtered_pixel;
    logic       cfg_write;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_wdata;

    // register image kept by the bench
    logic               mode16;
    taps_t              vert_coefs;
    taps_t              horiz_coefs;
    scale_t             vert_scale;
    scale_t             horiz_scale;
    logic signed [31:0] bias_q8;
    logic               clamp_neg;

    sample_t pending_pixels [$];
    sample_t want_pixel;
    int      fail_count  = 0;
    int      stall_cycles = 0;
    bit      gaps_on     = 1'b1;

    cross_convolution_5tap dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .column_top2    (column_top2),
        .column_top1    (column_top1),
        .column_center  (column_center),
        .column_bottom1 (column_bottom1),
        .column_bottom2 (column_bottom2),
        .row_left2      (row_left2),
        .row_left1      (row_left1),
        .row_right1     (row_right1),
        .row_right2     (row_right2),
        .done           (done),
        .filtered_pixel (filtered_pixel),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // one 5-tap pass: dot product, Q8.24 scale with saturation, optional bias, truncate, fold sign, clip
    function automatic longint tap_pass(input longint smp [5], input taps_t coefs,
                                        input scale_t scale, input bit add_bias,
                                        input longint ceiling);
        logic signed [COEF_BITS-1:0] coef;
        longint    acc;
        longint    k;
        longint    total;
        longint    q;
        bit [63:0] mag_s;
        bit [63:0] mag_k;
        bit [63:0] prod;
        bit        neg;
        acc = 0;
        for (int i = 0; i < TAP_COUNT; i++)
        begin
            coef = coefs[i*COEF_BITS +: COEF_BITS];
            acc += smp[i] * longint'(coef);
        end
        k     = longint'(scale);
        neg   = (acc < 0) != (k < 0);
        mag_s = (acc < 0) ? -acc : acc;
        mag_k = (k < 0) ? -k : k;
        if (mag_s != 0 && mag_k > PROD_LIMIT / mag_s)
            prod = PROD_LIMIT;
        else
            prod = mag_s * mag_k;
        total = neg ? -longint'(prod) : longint'(prod);
        if (add_bias)
            total += longint'(bias_q8) * BIAS_MUL;
        q = total / FRAC_DIV;
        if (q < 0)
            q = clamp_neg ? 0 : -q;
        if (q > ceiling)
            q = ceiling;
        return q;
    endfunction

    function automatic sample_t filter_pixel(input pixel_item_t it);
        longint mask;
        longint vcol [5];
        longint hrow [5];
        mask = mode16 ? longint'(SAMPLE_MAX_16) : longint'(SAMPLE_MAX_8);
        for (int i = 0; i < 5; i++)
            vcol[i] = longint'(it.col[i]) & mask;
        hrow[0] = longint'(it.nbr[0]) & mask;
        hrow[1] = longint'(it.nbr[1]) & mask;
        hrow[2] = tap_pass(vcol, vert_coefs, vert_scale, 1'b0, mask);
        hrow[3] = longint'(it.nbr[2]) & mask;
        hrow[4] = longint'(it.nbr[3]) & mask;
        return sample_t'(tap_pass(hrow, horiz_coefs, horiz_scale, 1'b1, mask));
    endfunction

    function automatic taps_t pack_coefs(input int c [5]);
        taps_t packed_taps;
        packed_taps = '0;
        for (int i = 0; i < 5; i++)
            packed_taps[i*COEF_BITS +: COEF_BITS] = c[i][COEF_BITS-1:0];
        return packed_taps;
    endfunction

    function automatic pixel_item_t uniform_item(input sample_t v);
        pixel_item_t it;
        for (int i = 0; i < 5; i++)
            it.col[i] = v;
        for (int i = 0; i < 4; i++)
            it.nbr[i] = v;
        return it;
    endfunction

    function automatic sample_t random_sample();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return SAMPLE_MAX_16;
        return sample_t'($urandom_range(65535));
    endfunction

    function automatic pixel_item_t random_pixel();
        pixel_item_t it;
        for (int i = 0; i < 5; i++)
            it.col[i] = random_sample();
        for (int i = 0; i < 4; i++)
            it.nbr[i] = random_sample();
        return it;
    endfunction

    task automatic send_pixel(input pixel_item_t it);
        // insert random idle cycles so about a fifth of the cycles carry no item
        while (gaps_on && $urandom_range(99) < 22)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start          <= 1'b1;
        column_top2    <= it.col[0];
        column_top1    <= it.col[1];
        column_center  <= it.col[2];
        column_bottom1 <= it.col[3];
        column_bottom2 <= it.col[4];
        row_left2      <= it.nbr[0];
        row_left1      <= it.nbr[1];
        row_right1     <= it.nbr[2];
        row_right2     <= it.nbr[3];
        do
            @(posedge clk);
        while (busy);
        pending_pixels.push_back(filter_pixel(it));
    endtask

    // drop start and hold until every pending pixel is back
    task automatic quiesce();
        @(negedge clk);
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            REG_SAMPLE_DEPTH:     mode16      = data[0];
            REG_VERTICAL_TAPS:    vert_coefs  = data[TAP_REG_W-1:0];
            REG_HORIZONTAL_TAPS:  horiz_coefs = data[TAP_REG_W-1:0];
            REG_VERTICAL_SCALE:   vert_scale  = data[SCALE_W-1:0];
            REG_HORIZONTAL_SCALE: horiz_scale = data[SCALE_W-1:0];
            REG_OUTPUT_BIAS:      bias_q8     = data[31:0];
            REG_CLAMP_NEGATIVES:  clamp_neg   = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic load_config(input logic mode, input taps_t vt, input taps_t ht,
                               input logic [31:0] vs, input logic [31:0] hs,
                               input logic [31:0] bias, input logic clamp);
        quiesce();
        write_reg(REG_SAMPLE_DEPTH, cfg_data_t'(mode));
        write_reg(REG_VERTICAL_TAPS, cfg_data_t'(vt));
        write_reg(REG_HORIZONTAL_TAPS, cfg_data_t'(ht));
        write_reg(REG_VERTICAL_SCALE, cfg_data_t'(vs));
        write_reg(REG_HORIZONTAL_SCALE, cfg_data_t'(hs));
        write_reg(REG_OUTPUT_BIAS, cfg_data_t'(bias));
        write_reg(REG_CLAMP_NEGATIVES, cfg_data_t'(clamp));
    endtask

    task automatic test_reset_defaults();
        send_pixel(uniform_item('0));
        send_pixel(uniform_item(SAMPLE_MAX_16));
    endtask

    task automatic test_passthrough();
        load_config(1'b1, pack_coefs('{0, 0, 1, 0, 0}), pack_coefs('{0, 0, 1, 0, 0}),
                    SCALE_ONE, SCALE_ONE, 32'd0, 1'b0);
        send_pixel(uniform_item(SAMPLE_MAX_16));
        send_pixel(random_pixel());
    endtask

    task automatic test_byte_mode();
        pixel_item_t it;
        load_config(1'b0, pack_coefs('{0, 0, 1, 0, 0}), pack_coefs('{1, 1, 1, 0, 0}),
                    SCALE_ONE, SCALE_ONE, 32'd0, 1'b0);
        it = uniform_item(16'hAB12);
        it.nbr[1] = 16'h5A80;
        send_pixel(it);
        send_pixel(uniform_item(SAMPLE_MAX_16));
    endtask

    // half scale on a negative column exercises truncation toward zero
    task automatic test_negative_results();
        pixel_item_t odd_item;
        pixel_item_t mixed_item;
        odd_item   = uniform_item(16'd3);
        mixed_item = random_pixel();
        for (int clamp = 0; clamp < 2; clamp++)
        begin
            load_config(1'b1, pack_coefs('{0, 0, -3, 0, 0}), pack_coefs('{1, 0, 1, 0, -2}),
                        32'h0080_0000, SCALE_ONE, 32'd0, clamp[0]);
            send_pixel(odd_item);
            send_pixel(mixed_item);
        end
    endtask

    task automatic test_saturation();
        load_config(1'b1, pack_coefs('{2047, 2047, 2047, 2047, 2047}),
                    pack_coefs('{-2048, -2048, -2048, -2048, -2048}),
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_pixel(uniform_item(SAMPLE_MAX_16));
        send_pixel(uniform_item('0));
        load_config(1'b1, '1, '1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1'b1);
        send_pixel(uniform_item(SAMPLE_MAX_16));
    endtask

    task automatic test_output_bias();
        load_config(1'b0, '0, '0, SCALE_ONE, SCALE_ONE, 32'd76800, 1'b0);
        send_pixel(random_pixel());
        load_config(1'b1, '0, '0, SCALE_ONE, SCALE_ONE, -32'sd76800, 1'b0);
        send_pixel(random_pixel());
        load_config(1'b1, '0, '0, SCALE_ONE, SCALE_ONE, 32'h8000_0000, 1'b0);
        send_pixel(random_pixel());
    endtask

    // high bits past each register and the spare index must leave the image alone
    task automatic test_register_masking();
        load_config(1'b1, pack_coefs('{1, 2, 3, 2, 1}), pack_coefs('{1, -1, 2, -1, 1}),
                    32'h0020_0000, SCALE_ONE, 32'd512, 1'b0);
        quiesce();
        write_reg(REG_UNUSED, '1);
        write_reg(REG_SAMPLE_DEPTH, cfg_data_t'('1) ^ cfg_data_t'(1));
        write_reg(REG_HORIZONTAL_SCALE, {28'hFFF_FFFF, 32'h0200_0000});
        write_reg(REG_CLAMP_NEGATIVES, '1);
        send_pixel(random_pixel());
        send_pixel(uniform_item(SAMPLE_MAX_16));
    endtask

    // coefficients in -16..16 with a scale that keeps results within twice the sample range
    task automatic pick_tame_pass(output taps_t coefs, output logic [31:0] scale);
        int     c [5];
        longint abs_sum;
        longint s;
        abs_sum = 0;
        for (int i = 0; i < 5; i++)
        begin
            c[i] = int'($urandom_range(32)) - 16;
            abs_sum += (c[i] < 0) ? -c[i] : c[i];
        end
        if (abs_sum == 0)
            abs_sum = 1;
        coefs = pack_coefs(c);
        s = (longint'(1) << FRAC_BITS) / abs_sum * $urandom_range(25, 200) / 100;
        if ($urandom_range(7) == 0)
            s = -s;
        scale = s[31:0];
    endtask

    task automatic test_random_phases();
        taps_t       vt, ht;
        logic [31:0] vs, hs, bias;
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase % 3 == 2)
            begin
                vt   = taps_t'({$urandom, $urandom});
                ht   = taps_t'({$urandom, $urandom});
                vs   = $urandom;
                hs   = $urandom;
                bias = $urandom;
            end
            else
            begin
                pick_tame_pass(vt, vs);
                pick_tame_pass(ht, hs);
                bias = int'($urandom_range(131072)) - 65536;
            end
            load_config(1'($urandom_range(1)), vt, ht, vs, hs, bias,
                        1'($urandom_range(1)));
            gaps_on = (phase != 3);
            for (int n = 0; n < 50; n++)
            begin
                if (phase == 1 && n == 25)
                    quiesce();
                send_pixel(random_pixel());
            end
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("filtered_pixel: expected nothing, got %0h", filtered_pixel);
                fail_count++;
            end
            else
            begin
                want_pixel = pending_pixels.pop_front();
                if (filtered_pixel !== want_pixel)
                begin
                    $error("filtered_pixel: expected %0h, got %0h", want_pixel, filtered_pixel);
                    fail_count++;
                end
            end
        end
    end

    // count cycles that move neither an item nor a result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        mode16      = 1'b0;
        vert_coefs  = '0;
        horiz_coefs = '0;
        vert_scale  = SCALE_ONE;
        horiz_scale = SCALE_ONE;
        bias_q8     = '0;
        clamp_neg   = 1'b0;

        rst_n          <= 1'b0;
        start          <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= '0;
        cfg_wdata      <= '0;
        column_top2    <= '0;
        column_top1    <= '0;
        column_center  <= '0;
        column_bottom1 <= '0;
        column_bottom2 <= '0;
        row_left2      <= '0;
        row_left1      <= '0;
        row_right1     <= '0;
        row_right2     <= '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_passthrough();
        test_byte_mode();
        test_negative_results();
        test_saturation();
        test_output_bias();
        test_register_masking();
        test_random_phases();

        quiesce();
        repeat (LATENCY + 4) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
